@@ rtl/wfa_pkg.sv @@
`default_nettype none
package wfa_pkg;

    localparam int ADDR_BITS = 16;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_NO_SPACE     = 3'd1;
    localparam logic [2:0] ST_TABLE_FULL   = 3'd2;
    localparam logic [2:0] ST_OUT_OF_RANGE = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND    = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN,
        S_FREE_RD,
        S_FREE,
        S_MOVE_RD,
        S_MOVE,
        S_INSERT,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

@@ rtl/wfa_table.sv @@
`default_nettype none
// Two-array block table: one write port, two registered read ports.
module wfa_table
#(
    parameter int IDX_BITS = 6,
    parameter int ADDR_BITS = 16
)
(
    input  wire                  clk,
    input  wire                  we,
    input  wire [IDX_BITS-1:0]   waddr,
    input  wire [ADDR_BITS-1:0]  wstart,
    input  wire [ADDR_BITS-1:0]  wsize,
    input  wire [IDX_BITS-1:0]   raddr_a,
    input  wire [IDX_BITS-1:0]   raddr_b,
    output logic [ADDR_BITS-1:0] start_a,
    output logic [ADDR_BITS-1:0] size_a,
    output logic [ADDR_BITS-1:0] start_b
);

    localparam int DEPTH = 1 << IDX_BITS;

    logic [ADDR_BITS-1:0] start_mem [DEPTH];
    logic [ADDR_BITS-1:0] size_mem  [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            start_mem[waddr] <= wstart;
            size_mem[waddr]  <= wsize;
        end
        start_a <= start_mem[raddr_a];
        size_a  <= size_mem[raddr_a];
        start_b <= start_mem[raddr_b];
    end

endmodule
`default_nettype wire

@@ rtl/worst_fit_block_allocator.sv @@
`default_nettype none
// Worst-fit allocator over a byte arena described by an address-ordered block table.
// Requests arrive on in_valid/in_stall: mode 0 allocates req_size bytes, mode 1 frees
// the block whose payload starts at free_addr. One result (status, addr) per request
// leaves on out_valid/out_stall. The block takes one request at a time; in_stall is
// high from acceptance until the result has been taken, and the next request can be
// taken the cycle after that.
// An allocate scans the table one entry per cycle through the shared gap/compare
// unit in S_SCAN, decides in S_SCAN_RD, then shifts the entries above the pick up
// by one (read in S_MOVE_RD, then write in S_MOVE) and writes the new entry in
// S_INSERT. A free reads each entry in S_FREE_RD and compares it in S_FREE; after a
// match it passes S_FREE_RD once more, then shifts the entries above down at one per
// cycle. The result is valid the cycle after the last step. Time grows with the
// entries scanned and shifted; a lightly filled table is far faster.
// Reset leaves only the sentinel (count one) and mem_size at 4096; entry 0 is
// written on the first cycle after reset. While out_stall is high the result
// holds and no new request is taken. mem_size is written with cfg_we.
module worst_fit_block_allocator
    import wfa_pkg::*;
#(
    parameter int MAX_BLOCKS = 64,
    parameter int HEADER_BYTES = 16
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire  [15:0] cfg_wdata,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire         mode,
    input  wire  [15:0] req_size,
    input  wire  [15:0] free_addr,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [2:0]  status,
    output logic [15:0] addr
);

    localparam int IB = $clog2(MAX_BLOCKS);
    localparam int CB = $clog2(MAX_BLOCKS + 1);
    localparam int W  = ADDR_BITS + 3;   // signed working width

    state_t state_reg, state_next;
    logic [15:0] mem_size_reg;
    logic [CB-1:0] count_reg, count_next;
    logic [CB-1:0] i_reg, i_next;
    logic [IB-1:0] pick_reg, pick_next;
    logic signed [W-1:0] best_reg, best_next;
    logic found_reg, found_next;
    logic init_reg;
    logic [15:0] size_reg, faddr_reg;
    logic [ADDR_BITS-1:0] pos_reg, pos_next;
    logic [2:0] status_reg, status_next;
    logic [15:0] addr_reg, addr_next;

    logic we;
    logic [IB-1:0] waddr, ra, rb;
    logic [ADDR_BITS-1:0] wstart, wsize, start_a, size_a, start_b;

    wfa_table #(.IDX_BITS(IB), .ADDR_BITS(ADDR_BITS)) u_table (
        .clk(clk), .we(we), .waddr(waddr), .wstart(wstart), .wsize(wsize),
        .raddr_a(ra), .raddr_b(rb), .start_a(start_a), .size_a(size_a),
        .start_b(start_b)
    );

    // shared gap/compare datapath
    logic signed [W-1:0] endp, limit, gap, diff, hdr;
    logic [CB-1:0] i_prev;
    logic last_entry;

    always_comb
    begin
        i_prev = i_reg - CB'(1);
        last_entry = (i_reg + CB'(1) == count_reg);
        endp  = W'(start_a) + W'(HEADER_BYTES) + W'(size_a);
        limit = last_entry ? W'(mem_size_reg) : W'(start_b);
        gap   = limit - endp;
        if (gap < 0)
            gap = '0;
        diff = gap - (W'(size_reg) + W'(HEADER_BYTES));
        hdr  = W'(faddr_reg) - W'(HEADER_BYTES);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            mem_size_reg <= 16'd4096;
            count_reg    <= CB'(1);
            init_reg     <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            init_reg  <= 1'b0;
            if (cfg_we)
                mem_size_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        pick_reg   <= pick_next;
        best_reg   <= best_next;
        found_reg  <= found_next;
        pos_reg    <= pos_next;
        status_reg <= status_next;
        addr_reg   <= addr_next;
        if (state_reg == S_IDLE && in_valid && !init_reg)
        begin
            size_reg  <= req_size;
            faddr_reg <= free_addr;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        i_next      = i_reg;
        pick_next   = pick_reg;
        best_next   = best_reg;
        found_next  = found_reg;
        pos_next    = pos_reg;
        status_next = status_reg;
        addr_next   = addr_reg;
        we     = init_reg;
        waddr  = '0;
        wstart = '0;
        wsize  = '0;
        ra     = i_reg[IB-1:0];
        rb     = IB'(i_reg + CB'(1));
        in_stall  = (state_reg != S_IDLE) || init_reg;
        out_valid = (state_reg == S_DONE);

        case (state_reg)
            S_IDLE:
            begin
                i_next = '0;
                ra     = '0;
                rb     = IB'(1);
                if (in_valid && !init_reg)
                begin
                    best_next   = '0;
                    found_next  = 1'b0;
                    pick_next   = '0;
                    addr_next   = '0;
                    state_next  = mode ? S_FREE_RD : S_SCAN;
                    if (mode)
                        i_next = CB'(1);
                end
            end
            S_SCAN:
            begin
                // table read of entry i is registered; evaluate it now
                if (diff > best_reg)
                begin
                    best_next  = diff;
                    pick_next  = i_reg[IB-1:0];
                    found_next = 1'b1;
                end
                // the limit read at i+1 uses rb issued last cycle
                i_next = i_reg + CB'(1);
                ra     = IB'(i_reg + CB'(1));
                rb     = IB'(i_reg + CB'(2));
                if (i_reg + CB'(1) == count_reg)
                    state_next = S_SCAN_RD;
            end
            S_SCAN_RD:
            begin
                // final decision; read pick entry
                ra = pick_reg;
                if (!found_reg)
                begin
                    status_next = ST_NO_SPACE;
                    state_next  = S_DONE;
                end
                else if (count_reg >= CB'(MAX_BLOCKS))
                begin
                    status_next = ST_TABLE_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    i_next     = count_reg;
                    state_next = S_MOVE_RD;
                end
            end
            S_MOVE_RD:
            begin
                // start_a/size_a hold the pick entry on first entry here
                if (i_reg == count_reg)
                    pos_next = ADDR_BITS'(start_a + ADDR_BITS'(HEADER_BYTES) + size_a);
                if (i_reg == CB'(pick_reg) + CB'(1))
                    state_next = S_INSERT;
                else
                begin
                    ra         = i_prev[IB-1:0];
                    state_next = S_MOVE;
                end
            end
            S_MOVE:
            begin
                we     = 1'b1;
                waddr  = i_reg[IB-1:0];
                wstart = start_a;
                wsize  = size_a;
                i_next = i_prev;
                state_next = S_MOVE_RD;
            end
            S_INSERT:
            begin
                we     = 1'b1;
                waddr  = i_reg[IB-1:0];
                wstart = pos_reg;
                wsize  = ADDR_BITS'(size_reg);
                count_next  = count_reg + CB'(1);
                status_next = ST_OK;
                addr_next   = 16'(pos_reg + ADDR_BITS'(HEADER_BYTES));
                state_next  = S_DONE;
            end
            S_FREE_RD:
            begin
                if (hdr <= 0 || hdr >= W'(mem_size_reg))
                begin
                    status_next = ST_OUT_OF_RANGE;
                    state_next  = S_DONE;
                end
                else if (i_reg >= count_reg)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
                else
                    state_next = S_FREE;
            end
            S_FREE:
            begin
                // start_a holds entry i
                if (W'(start_a) == hdr)
                begin
                    // shift entries above down: read i+1, write i
                    ra = IB'(i_reg + CB'(1));
                    if (i_reg + CB'(1) >= count_reg)
                    begin
                        count_next  = count_reg - CB'(1);
                        status_next = ST_OK;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        i_next     = i_reg + CB'(1);
                        state_next = S_FREE_RD;
                        found_next = 1'b1;
                    end
                end
                else
                begin
                    ra         = IB'(i_reg + CB'(1));
                    i_next     = i_reg + CB'(1);
                    state_next = S_FREE_RD;
                end
                if (found_reg)
                begin
                    // compaction mode: copy entry i to i-1
                    we     = 1'b1;
                    waddr  = i_prev[IB-1:0];
                    wstart = start_a;
                    wsize  = size_a;
                    ra     = IB'(i_reg + CB'(1));
                    if (i_reg + CB'(1) >= count_reg)
                    begin
                        count_next  = count_reg - CB'(1);
                        status_next = ST_OK;
                        state_next  = S_DONE;
                        i_next      = i_reg;
                    end
                    else
                    begin
                        i_next     = i_reg + CB'(1);
                        state_next = S_FREE;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase

        if (state_reg == S_FREE_RD && found_reg)
            state_next = S_FREE;
    end

    assign status = status_reg;
    assign addr   = addr_reg;

endmodule
`default_nettype wire
